@@ rtl/etsp_pkg.sv @@
// package for the exclusive time scope profiler
// shared constants and types; no dependencies
package etsp_pkg;

    localparam int TableSlots = 16;
    localparam int StackDepth = 16;
    localparam int TimeBits   = 48;

    typedef enum logic [1:0] {
        CMD_ENTER = 2'd0,
        CMD_EXIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_UNUSED    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SEARCH,
        FS_CHARGE,
        FS_UPDATE,
        FS_RESUME,
        FS_DONE
    } fsm_t;

    // request travelling down the cell chain
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
    } probe_t;

endpackage

@@ rtl/etsp_cell.sv @@
// one key cell of the lookup chain
// depends on etsp_pkg
module etsp_cell #(
    parameter int IDX_BITS = 4,
    parameter int MY_INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 wr_en,
    input  logic [31:0]          wr_key,
    input  logic [IDX_BITS:0]    used,
    input  etsp_pkg::probe_t     probe_in,
    input  logic                 hit_in,
    input  logic [IDX_BITS-1:0]  hit_idx_in,
    output etsp_pkg::probe_t     probe_out,
    output logic                 hit_out,
    output logic [IDX_BITS-1:0]  hit_idx_out
);

    logic [31:0]         key_reg;
    logic                probe_valid_reg;
    logic [31:0]         probe_key_reg;
    logic                hit_reg;
    logic [IDX_BITS-1:0] hit_idx_reg;
    logic                match;

    // the cell is live only once its slot has been allocated
    assign match = probe_in.valid && !hit_in &&
                   ((IDX_BITS+1)'(MY_INDEX) < used) && (key_reg == probe_in.key);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg <= wr_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else if (load)
        begin
            probe_valid_reg <= probe_in.valid;
            hit_reg         <= hit_in || match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            probe_key_reg <= probe_in.key;
            hit_idx_reg   <= match ? IDX_BITS'(MY_INDEX) : hit_idx_in;
        end
    end

    assign probe_out.valid = probe_valid_reg;
    assign probe_out.key   = probe_key_reg;
    assign hit_out         = hit_reg;
    assign hit_idx_out     = hit_idx_reg;

endmodule

@@ rtl/exclusive_time_scope_profiler.sv @@
// exclusive time scope profiler: top level with command sequencer and tables
// depends on etsp_pkg and etsp_cell
//
// One command is handled at a time. An enter sends its key down a chain of
// TABLE_SLOTS key cells, one cell per cycle, for the lookup; then it passes
// through the charge, update, resume and done states. An enter that finds the
// table full goes from the lookup straight to done, an exit passes through
// charge, update, resume and done, and a read, an unused command, an enter on
// a full stack or an exit on an empty stack go straight to done. The chain
// length sets the enter rate. The result waits in an output register; in_stall
// is high while a command is in flight or its result has not been taken, so
// the next transfer comes at the earliest in the cycle after the result
// transfer.
module exclusive_time_scope_profiler #(
    parameter int TABLE_SLOTS = etsp_pkg::TableSlots,
    parameter int STACK_DEPTH = etsp_pkg::StackDepth,
    parameter int TIME_BITS   = etsp_pkg::TimeBits,
    localparam int IB = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    localparam int SB = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [TIME_BITS-1:0] timestamp,
    input  logic [15:0]          context_id,
    input  logic [15:0]          name_id,
    input  logic [IB-1:0]        entry_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [IB-1:0]        slot,
    output logic [31:0]          call_count,
    output logic [TIME_BITS-1:0] elapsed_ticks,
    output logic [IB:0]          used_slots,
    output logic [SB:0]          depth
);

    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // tables
    logic [31:0]          call_mem    [TABLE_SLOTS];
    logic [TIME_BITS-1:0] elapsed_mem [TABLE_SLOTS];
    logic [TIME_BITS-1:0] start_mem   [TABLE_SLOTS];
    logic [IB-1:0]        stack_mem   [STACK_DEPTH];

    etsp_pkg::fsm_t state_reg, state_next;
    logic [IB:0]    used_reg;
    logic [SB:0]    sp_reg;
    logic [IB:0]    cnt_reg;
    logic [1:0]     cmd_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [31:0]    key_reg;
    logic [IB-1:0]  s_reg;
    logic           hit_reg;
    logic [IB-1:0]  top_reg;
    logic [TIME_BITS-1:0] top_el_reg, top_st_reg;

    logic           out_valid_reg;
    logic [2:0]     status_reg;
    logic [IB-1:0]  slot_reg;
    logic [31:0]    calls_reg;
    logic [TIME_BITS-1:0] ticks_reg;

    logic in_xfer, out_xfer, busy;
    assign busy     = (state_reg != etsp_pkg::FS_IDLE) || out_valid_reg;
    assign in_stall = busy;
    assign in_xfer  = in_valid && !busy;
    assign out_xfer = out_valid_reg && !out_stall;

    // cell chain
    etsp_pkg::probe_t    probe [TABLE_SLOTS+1];
    logic                hit   [TABLE_SLOTS+1];
    logic [IB-1:0]       hidx  [TABLE_SLOTS+1];
    logic                chain_load, key_wr;

    assign probe[0].valid = (state_reg == etsp_pkg::FS_SEARCH) && (cnt_reg == '0);
    assign probe[0].key   = key_reg;
    assign hit[0]         = 1'b0;
    assign hidx[0]        = '0;
    assign chain_load     = (state_reg == etsp_pkg::FS_SEARCH);

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++)
        begin : g_cell
            etsp_cell #(.IDX_BITS(IB), .MY_INDEX(g)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load       (chain_load),
                .wr_en      (key_wr && (s_reg == IB'(g))),
                .wr_key     (key_reg),
                .used       (used_reg),
                .probe_in   (probe[g]),
                .hit_in     (hit[g]),
                .hit_idx_in (hidx[g]),
                .probe_out  (probe[g+1]),
                .hit_out    (hit[g+1]),
                .hit_idx_out(hidx[g+1])
            );
        end
    endgenerate

    // charge arithmetic for the current top
    logic [TIME_BITS-1:0] run, room, charged;
    assign run     = now_reg - top_st_reg;
    assign room    = TMAX - top_el_reg;
    assign charged = (run > room) ? TMAX : top_el_reg + run;

    logic search_done;
    assign search_done = (state_reg == etsp_pkg::FS_SEARCH) &&
                         (cnt_reg == (IB+1)'(TABLE_SLOTS));
    logic do_fail;
    assign key_wr = (state_reg == etsp_pkg::FS_UPDATE) && (cmd_reg == etsp_pkg::CMD_ENTER)
                    && !hit_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            etsp_pkg::FS_IDLE:
            begin
                if (in_xfer)
                begin
                    case (cmd)
                        etsp_pkg::CMD_ENTER:
                            state_next = (sp_reg >= (SB+1)'(STACK_DEPTH)) ?
                                         etsp_pkg::FS_DONE : etsp_pkg::FS_SEARCH;
                        etsp_pkg::CMD_EXIT:
                            state_next = (sp_reg == '0) ? etsp_pkg::FS_DONE
                                                        : etsp_pkg::FS_CHARGE;
                        default: state_next = etsp_pkg::FS_DONE;
                    endcase
                end
            end
            etsp_pkg::FS_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = (!hit[TABLE_SLOTS] && used_reg >= (IB+1)'(TABLE_SLOTS)) ?
                                 etsp_pkg::FS_DONE : etsp_pkg::FS_CHARGE;
                end
            end
            etsp_pkg::FS_CHARGE: state_next = etsp_pkg::FS_UPDATE;
            etsp_pkg::FS_UPDATE: state_next = etsp_pkg::FS_RESUME;
            etsp_pkg::FS_RESUME: state_next = etsp_pkg::FS_DONE;
            etsp_pkg::FS_DONE:   state_next = etsp_pkg::FS_IDLE;
            default:             state_next = etsp_pkg::FS_IDLE;
        endcase
    end

    assign do_fail = search_done && !hit[TABLE_SLOTS] && used_reg >= (IB+1)'(TABLE_SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= etsp_pkg::FS_IDLE;
            used_reg      <= '0;
            sp_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == etsp_pkg::FS_SEARCH)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (key_wr)
                used_reg <= used_reg + 1'b1;
            if (state_reg == etsp_pkg::FS_UPDATE)
            begin
                if (cmd_reg == etsp_pkg::CMD_ENTER)
                    sp_reg <= sp_reg + 1'b1;
                else
                    sp_reg <= sp_reg - 1'b1;
            end
            if (state_reg == etsp_pkg::FS_DONE)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath and result register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg    <= cmd;
            now_reg    <= timestamp;
            key_reg    <= {context_id, name_id};
            hit_reg    <= 1'b0;
            if (sp_reg != '0)
                top_reg <= stack_mem[SB'(sp_reg - 1'b1)];
            case (cmd)
                etsp_pkg::CMD_ENTER:
                begin
                    status_reg <= (sp_reg >= (SB+1)'(STACK_DEPTH)) ?
                                  etsp_pkg::ST_OVERFLOW : etsp_pkg::ST_OK;
                    slot_reg   <= '0;
                    calls_reg  <= '0;
                    ticks_reg  <= '0;
                end
                etsp_pkg::CMD_EXIT:
                begin
                    status_reg <= (sp_reg == '0) ? etsp_pkg::ST_EMPTY : etsp_pkg::ST_OK;
                    slot_reg   <= '0;
                    calls_reg  <= '0;
                    ticks_reg  <= '0;
                end
                etsp_pkg::CMD_READ:
                begin
                    slot_reg <= entry_index;
                    if ({1'b0, entry_index} >= used_reg ||
                        32'(entry_index) >= 32'(TABLE_SLOTS))
                    begin
                        status_reg <= etsp_pkg::ST_UNUSED;
                        calls_reg  <= '0;
                        ticks_reg  <= '0;
                    end
                    else
                    begin
                        status_reg <= etsp_pkg::ST_OK;
                        calls_reg  <= call_mem[entry_index];
                        ticks_reg  <= elapsed_mem[entry_index];
                    end
                end
                default:
                begin
                    status_reg <= etsp_pkg::ST_OK;
                    slot_reg   <= '0;
                    calls_reg  <= '0;
                    ticks_reg  <= '0;
                end
            endcase
        end
        if (search_done)
        begin
            hit_reg <= hit[TABLE_SLOTS];
            s_reg   <= hit[TABLE_SLOTS] ? hidx[TABLE_SLOTS] : IB'(used_reg);
            if (do_fail)
                status_reg <= etsp_pkg::ST_FULL;
        end
        if (state_reg == etsp_pkg::FS_IDLE && in_xfer && cmd == etsp_pkg::CMD_EXIT)
            s_reg <= (sp_reg != '0) ? stack_mem[SB'(sp_reg - 1'b1)] : '0;
        // fetch top for charging
        if (state_reg == etsp_pkg::FS_CHARGE)
        begin
            top_el_reg <= elapsed_mem[top_reg];
            top_st_reg <= start_mem[top_reg];
        end
        if (state_reg == etsp_pkg::FS_UPDATE)
        begin
            if (sp_reg != '0)
                elapsed_mem[top_reg] <= charged;
            if (cmd_reg == etsp_pkg::CMD_ENTER)
            begin
                start_mem[s_reg] <= now_reg;
                stack_mem[SB'(sp_reg)] <= s_reg;
                if (!hit_reg)
                begin
                    call_mem[s_reg]    <= 32'd1;
                    elapsed_mem[s_reg] <= '0;
                end
                else if (call_mem[s_reg] != '1)
                    call_mem[s_reg] <= call_mem[s_reg] + 1'b1;
            end
            else if (sp_reg > (SB+1)'(1))
                top_reg <= stack_mem[SB'(sp_reg - 2'd2)];
        end
        if (state_reg == etsp_pkg::FS_RESUME)
        begin
            if (cmd_reg == etsp_pkg::CMD_EXIT && sp_reg != '0)
                start_mem[top_reg] <= now_reg;
            slot_reg  <= s_reg;
            calls_reg <= call_mem[s_reg];
            ticks_reg <= elapsed_mem[s_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign call_count    = calls_reg;
    assign elapsed_ticks = ticks_reg;
    assign used_slots    = used_reg;
    assign depth         = sp_reg;

    // checks
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= (SB+1)'(STACK_DEPTH)) else $error("stack pointer past depth");
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= (IB+1)'(TABLE_SLOTS)) else $error("slot count past table");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == etsp_pkg::FS_IDLE) else $error("busy with result held");

endmodule

@@ tb/etsp_checker.sv @@
// checker for the exclusive time scope profiler: watches both channels,
// predicts each result and compares it; depends on etsp_pkg
module etsp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [47:0] timestamp,
    input  logic [15:0] context_id,
    input  logic [15:0] name_id,
    input  logic [3:0]  entry_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [3:0]  slot,
    input  logic [31:0] call_count,
    input  logic [47:0] elapsed_ticks,
    input  logic [4:0]  used_slots,
    input  logic [4:0]  depth,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] TickMax = '1;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] calls;
        logic [47:0] ticks;
        logic [4:0]  used;
        logic [4:0]  depth;
    } scope_result_t;

    logic [31:0] keys   [16];
    logic [31:0] calls  [16];
    logic [47:0] ticks  [16];
    logic [47:0] starts [16];
    logic [3:0]  scope_stack [16];
    int          n_slots;
    int          sp;
    scope_result_t expected_mem [16];
    int          wr_count = 0;
    int          rd_count = 0;

    assign pending = wr_count - rd_count;

    function automatic void charge_slot(int s, logic [47:0] now);
        logic [47:0] run;
        run = now - starts[s];
        ticks[s] = (run > TickMax - ticks[s]) ? TickMax : ticks[s] + run;
    endfunction

    function automatic scope_result_t profile_step(logic [1:0] c, logic [47:0] now,
                                                   logic [31:0] key, logic [3:0] idx);
        scope_result_t r;
        int s;
        bit hit;
        r = '0;
        hit = 0;
        s = 0;
        case (c)
            etsp_pkg::CMD_ENTER:
            begin
                if (sp >= 16)
                    r.status = etsp_pkg::ST_OVERFLOW;
                else
                begin
                    for (int i = 0; i < n_slots; i++)
                        if (!hit && keys[i] == key)
                        begin
                            hit = 1;
                            s = i;
                        end
                    if (!hit && n_slots >= 16)
                        r.status = etsp_pkg::ST_FULL;
                    else
                    begin
                        if (sp > 0)
                            charge_slot(scope_stack[sp-1], now);
                        if (hit)
                        begin
                            if (calls[s] != '1)
                                calls[s]++;
                        end
                        else
                        begin
                            s = n_slots;
                            keys[s] = key;
                            calls[s] = 32'd1;
                            ticks[s] = '0;
                            n_slots++;
                        end
                        starts[s] = now;
                        scope_stack[sp] = 4'(s);
                        sp++;
                        r.status = etsp_pkg::ST_OK;
                        r.slot = 4'(s);
                        r.calls = calls[s];
                        r.ticks = ticks[s];
                    end
                end
            end
            etsp_pkg::CMD_EXIT:
            begin
                if (sp == 0)
                    r.status = etsp_pkg::ST_EMPTY;
                else
                begin
                    s = scope_stack[sp-1];
                    charge_slot(s, now);
                    sp--;
                    if (sp > 0)
                        starts[scope_stack[sp-1]] = now;
                    r.slot = 4'(s);
                    r.calls = calls[s];
                    r.ticks = ticks[s];
                end
            end
            etsp_pkg::CMD_READ:
            begin
                r.slot = idx;
                if (idx >= n_slots)
                    r.status = etsp_pkg::ST_UNUSED;
                else
                begin
                    r.calls = calls[idx];
                    r.ticks = ticks[idx];
                end
            end
            default: ;
        endcase
        r.used = 5'(n_slots);
        r.depth = 5'(sp);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scope_result_t got, exp_r;
        if (!rst_n)
        begin
            n_slots = 0;
            sp = 0;
            fail_count = 0;
            wr_count = 0;
            rd_count = 0;
        end
        else
        begin
            // result side first; the block cannot answer in the cycle it accepts
            if (out_valid && !out_stall)
            begin
                got = {status, slot, call_count, elapsed_ticks, used_slots, depth};
                if (wr_count == rd_count)
                begin
                    fail_count++;
                    $display("%0t: unexpected result %h, expected none", $time, got);
                end
                else
                begin
                    exp_r = expected_mem[rd_count[3:0]];
                    rd_count++;
                    if (got.status !== exp_r.status || got.slot !== exp_r.slot ||
                        got.calls !== exp_r.calls || got.ticks !== exp_r.ticks ||
                        got.used !== exp_r.used || got.depth !== exp_r.depth)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected st=%0d slot=%0d calls=%0d ticks=%h used=%0d depth=%0d",
                                 $time, exp_r.status, exp_r.slot, exp_r.calls, exp_r.ticks,
                                 exp_r.used, exp_r.depth);
                        $display("%0t:          actual   st=%0d slot=%0d calls=%0d ticks=%h used=%0d depth=%0d",
                                 $time, got.status, got.slot, got.calls, got.ticks,
                                 got.used, got.depth);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (wr_count - rd_count >= 16)
                begin
                    fail_count++;
                    $display("%0t: more than 16 results outstanding", $time);
                end
                else
                begin
                    expected_mem[wr_count[3:0]] = profile_step(cmd, timestamp,
                                                               {context_id, name_id},
                                                               entry_index);
                    wr_count++;
                end
            end
        end
    end
endmodule

@@ tb/tb.sv @@
// top of the profiler testbench: clock, reset, stimulus and verdict
// depends on etsp_pkg, etsp_checker and the profiler rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  cmd = etsp_pkg::CMD_NONE;
    logic [47:0] timestamp = '0;
    logic [15:0] context_id = '0;
    logic [15:0] name_id = '0;
    logic [3:0]  entry_index = '0;
    logic        out_valid;
    logic        out_stall = 1;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] call_count;
    logic [47:0] elapsed_ticks;
    logic [4:0]  used_slots;
    logic [4:0]  depth;
    int          fail_count;
    int          pending;
    int          n_cycles = 0;
    bit          long_hold = 0;

    // model of what the sender believes, only to shape well-formed nesting
    int          model_depth = 0;
    logic [47:0] clock_now = 48'h0000_1000_0000;
    logic [31:0] key_pool [16];

    always #10 clk = ~clk;

    exclusive_time_scope_profiler u_dut (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .timestamp, .context_id,
        .name_id, .entry_index, .out_valid, .out_stall, .status, .slot,
        .call_count, .elapsed_ticks, .used_slots, .depth
    );

    etsp_checker u_chk (.*);

    // cycle limit: ~1400 transfers plus stalls, many times over
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 600000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: own stall pattern, one long hold-off early in the random part
    initial
    begin
        int hold;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1;
                hold = 0;
                while (hold < 300)
                begin
                    @(posedge clk);
                    hold++;
                end
                long_hold = 0;
                out_stall <= 0;
            end
            else if (n_cycles % 2000 < 600)
                out_stall <= 0;
            else
                out_stall <= ($urandom_range(0, 99) < 40);
        end
    end

    // one transfer: present the item and wait for acceptance
    task automatic send_item(logic [1:0] c, logic [47:0] ts, logic [15:0] ctx,
                             logic [15:0] nm, logic [3:0] idx);
        in_valid <= 1;
        cmd <= c;
        timestamp <= ts;
        context_id <= ctx;
        name_id <= nm;
        entry_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst;
        int roll;
        int c;
        logic [31:0] k;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty exit, unused read, unused command, extreme fields
        send_item(etsp_pkg::CMD_EXIT, '0, '0, '0, '0);
        send_item(etsp_pkg::CMD_READ, '1, '1, '1, 4'hf);
        send_item(etsp_pkg::CMD_NONE, '1, '1, '1, 4'hf);
        send_item(etsp_pkg::CMD_ENTER, 48'hffff_ffff_fff0, 16'hffff, 16'hffff, '0);
        // wrap of time: nested scope entered after counter wraps
        send_item(etsp_pkg::CMD_ENTER, 48'h0000_0000_0010, 16'h0000, 16'h0000, '0);
        send_item(etsp_pkg::CMD_ENTER, 48'h0000_0000_0020, 16'hffff, 16'hffff, '0); // recursion
        send_item(etsp_pkg::CMD_EXIT, 48'h0000_0000_0030, '0, '0, '0);
        send_item(etsp_pkg::CMD_EXIT, 48'h8000_0000_0000, '0, '0, '0);
        send_item(etsp_pkg::CMD_EXIT, 48'h7fff_ffff_ffff, '0, '0, '0); // near-full interval
        send_item(etsp_pkg::CMD_READ, '0, '0, '0, 4'd0);
        send_item(etsp_pkg::CMD_READ, '0, '0, '0, 4'd1);
        // fill the table, then one more new key, then overflow the stack
        for (int i = 0; i < 14; i++)
            send_item(etsp_pkg::CMD_ENTER, 48'h100 + 48'(i), 16'h5a00 + 16'(i),
                      16'ha5a5, '0);
        send_item(etsp_pkg::CMD_ENTER, 48'h200, 16'h1234, 16'h4321, '0);  // table full
        send_item(etsp_pkg::CMD_ENTER, 48'h210, 16'hffff, 16'hffff, '0);  // 15 deep
        send_item(etsp_pkg::CMD_ENTER, 48'h220, 16'h0000, 16'h0000, '0);  // 16 deep
        send_item(etsp_pkg::CMD_ENTER, 48'h230, 16'h0000, 16'h0000, '0);  // overflow
        for (int i = 0; i < 16; i++)
            send_item(etsp_pkg::CMD_EXIT, 48'h300 + 48'(i * 7), '0, '0, '0);
        drain();
        model_depth = 0;
        clock_now = 48'hffff_ffff_0000;

        // random part: mostly nested enter/exit over a hot key set, plus noise.
        // table is full after directed part, so keys come from what is there
        key_pool[0] = {16'hffff, 16'hffff};
        key_pool[1] = 32'h0;
        for (int i = 2; i < 16; i++)
            key_pool[i] = {16'h5a00 + 16'(i) - 16'd2, 16'ha5a5};
        for (int n = 0; n < 1300; n++)
        begin
            if (n == 100)
                long_hold = 1;
            if (n == 700)
                drain();
            burst = $urandom_range(0, 9);
            if (burst == 0)
                idle_cycles($urandom_range(1, 30));
            roll = $urandom_range(0, 99);
            // big steps occasionally so time differences wrap and saturate
            clock_now = clock_now + (($urandom_range(0, 19) == 0) ?
                        48'({$urandom(), $urandom()}) : 48'($urandom_range(0, 5000)));
            if (roll < 45)
                c = etsp_pkg::CMD_ENTER;
            else if (roll < 88)
                c = etsp_pkg::CMD_EXIT;
            else if (roll < 97)
                c = etsp_pkg::CMD_READ;
            else
                c = etsp_pkg::CMD_NONE;
            if (c == etsp_pkg::CMD_ENTER && model_depth > 12 && roll < 40)
                c = etsp_pkg::CMD_EXIT;
            if (roll < 5)
                k = {$urandom()} ;  // new key: table full
            else
                k = key_pool[$urandom_range(0, 15)];
            send_item(c[1:0], clock_now, k[31:16], k[15:0], 4'($urandom_range(0, 15)));
            if (c == etsp_pkg::CMD_ENTER && roll >= 5 && model_depth < 16)
                model_depth++;
            else if (c == etsp_pkg::CMD_EXIT && model_depth > 0)
                model_depth--;
        end
        drain();
        idle_cycles(50);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
